[sv/bb3_pkg.sv]
// ---------------------------------------------------------------------------
// bb3_pkg: shared constants, types and helpers of the 3x3 box blur
// Sizes of the line memory, the column-sum types and the divide-by-nine helper.
// ---------------------------------------------------------------------------
package bb3_pkg;

	// Largest interior side and the depth of one line store.
	localparam int MAX_INTERIOR = 256;
	localparam int LINE_DEPTH   = MAX_INTERIOR + 2;
	localparam int ADDR_W       = $clog2(LINE_DEPTH);

	// Register and pixel widths.
	localparam int SIZE_W     = 9;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int LINE_W     = 2 * PIX_W;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_INTERIOR);
	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(1);

	// A column of three bytes sums to 10 bits, nine bytes to 12 bits.
	localparam int COL_W = CH_W + 2;
	localparam int SUM_W = CH_W + 4;

	// Reciprocal of nine in 16 fractional bits; exact floor for sums up to 2295.
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

	typedef struct packed {
		logic [COL_W-1:0] b;
		logic [COL_W-1:0] g;
		logic [COL_W-1:0] r;
	} col_sum_t;

	typedef struct packed {
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] r;
	} win_sum_t;

	// Sum of three bytes.
	function automatic logic [COL_W-1:0] add3(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b, input logic [CH_W-1:0] c);
		return COL_W'(a) + COL_W'(b) + COL_W'(c);
	endfunction

	// Sum of three column sums.
	function automatic logic [SUM_W-1:0] add3c(input logic [COL_W-1:0] a,
		input logic [COL_W-1:0] b, input logic [COL_W-1:0] c);
		return SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
	endfunction

	// Truncated division by nine through a reciprocal multiply.
	function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
		logic [SUM_W+RECIP_W-1:0] prod;
		prod = {{RECIP_W{1'b0}}, x} * {{SUM_W{1'b0}}, RECIP_9};
		return prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
	endfunction

endpackage

[sv/box_blur_3x3_rgb_crop_core.sv]
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_crop_core: 3x3 mean filter over an RGB raster, border cropped
// Two input rows live in one line memory; a window of column sums gives the
// nine-pixel mean per channel for every interior position.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ---------------------------------------
//  input     in_valid / in_stall    red_in, green_in, blue_in
//  output    out_valid / out_stall  red_avg, green_avg, blue_avg, frame_end
//  config    cfg_we                 cfg_wdata (interior_size)
//
//  One pixel is taken per clock while in_stall is low; results are registered.
//  The line memory is read when a pixel is taken and written back when the pixel
//  leaves stage 1, so each memory port sees one access per pixel.
//  Reset clears the handshake state and the positions and sets the size to 64.
//  A stalled output holds only the stages behind it that are full; bubbles close.
//  Border pixels produce no request and leave the pipeline after stage 1.
//
module box_blur_3x3_rgb_crop_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bb3_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [bb3_pkg::CH_W-1:0]  red_in,
	input  logic [bb3_pkg::CH_W-1:0]  green_in,
	input  logic [bb3_pkg::CH_W-1:0]  blue_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bb3_pkg::CH_W-1:0]  red_avg,
	output logic [bb3_pkg::CH_W-1:0]  green_avg,
	output logic [bb3_pkg::CH_W-1:0]  blue_avg,
	output logic                      frame_end
);
	import bb3_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] side_m1;
	logic [ADDR_W-1:0] col_q;
	logic [SIZE_W-1:0] row_q;
	logic              in_acc;
	logic              at_emit;
	logic              at_last;

	logic              s1_valid;
	logic [ADDR_W-1:0] s1_addr;
	logic [PIX_W-1:0]  s1_px;
	logic              s1_emit;
	logic              s1_last;
	logic              s1_go;
	logic              s1_free;
	logic [LINE_W-1:0] line_rd;
	logic [PIX_W-1:0]  top_px;
	logic [PIX_W-1:0]  mid_px;
	col_sum_t          col_sum;

	col_sum_t          win_a_q;
	col_sum_t          win_b_q;

	logic              s2_valid;
	win_sum_t          s2_sum;
	logic              s2_last;
	logic              s2_go;
	logic              s2_free;
	logic              out_free;

	// Effective side minus one: a size of zero acts as one, large sizes clamp.
	always_comb begin
		if (size_q == '0) begin
			side_m1 = SIZE_MIN + SIZE_W'(1);
		end else if (size_q > SIZE_MAX) begin
			side_m1 = SIZE_MAX + SIZE_W'(1);
		end else begin
			side_m1 = size_q + SIZE_W'(1);
		end
	end

	// Stages move when the next has room; border pixels need no room.
	assign out_free = !out_valid || !out_stall;
	assign s2_go    = s2_valid && out_free;
	assign s2_free  = !s2_valid || s2_go;
	assign s1_go    = s1_valid && (!s1_emit || s2_free);
	assign s1_free  = !s1_valid || s1_go;
	assign in_stall = !s1_free;
	assign in_acc   = in_valid && !in_stall;

	// Position of the incoming pixel.
	assign at_emit = (row_q >= SIZE_W'(2)) && (SIZE_W'(col_q) >= SIZE_W'(2));
	assign at_last = (row_q == side_m1) && (SIZE_W'(col_q) == side_m1);

	// Size register and raster position; a size write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
			col_q  <= '0;
			row_q  <= '0;
		end else if (in_acc) begin
			if (SIZE_W'(col_q) == side_m1) begin
				col_q <= '0;
				row_q <= (row_q == side_m1) ? '0 : row_q + SIZE_W'(1);
			end else begin
				col_q <= col_q + ADDR_W'(1);
			end
		end
	end

	// Line memory: upper row in the high half, middle row in the low half.
	bb3_ram #(
		.WIDTH(LINE_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (s1_go),
		.waddr(s1_addr),
		.wdata({mid_px, s1_px}),
		.re   (in_acc),
		.raddr(col_q),
		.rdata(line_rd)
	);

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s1_free) begin
			s1_valid <= in_acc;
		end
	end

	// Stage 1 payload: the pixel waits here for its column from the line memory.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_addr <= col_q;
			s1_px   <= {blue_in, green_in, red_in};
			s1_emit <= at_emit;
			s1_last <= at_last;
		end
	end

	assign top_px = line_rd[LINE_W-1:PIX_W];
	assign mid_px = line_rd[PIX_W-1:0];

	// Vertical sum of the current column per channel.
	always_comb begin
		col_sum.r = add3(top_px[CH_W-1:0], mid_px[CH_W-1:0], s1_px[CH_W-1:0]);
		col_sum.g = add3(top_px[2*CH_W-1:CH_W], mid_px[2*CH_W-1:CH_W],
			s1_px[2*CH_W-1:CH_W]);
		col_sum.b = add3(top_px[PIX_W-1:2*CH_W], mid_px[PIX_W-1:2*CH_W],
			s1_px[PIX_W-1:2*CH_W]);
	end

	// Window of the two previous column sums.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			win_a_q <= win_b_q;
			win_b_q <= col_sum;
		end
	end

	// Stage 2 control: only interior pixels go on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s1_go && s1_emit) begin
			s2_valid <= 1'b1;
		end else if (s2_go) begin
			s2_valid <= 1'b0;
		end
	end

	// Stage 2 payload: nine-pixel sums.
	always_ff @(posedge clk) begin
		if (s1_go && s1_emit) begin
			s2_sum.r <= add3c(win_a_q.r, win_b_q.r, col_sum.r);
			s2_sum.g <= add3c(win_a_q.g, win_b_q.g, col_sum.g);
			s2_sum.b <= add3c(win_a_q.b, win_b_q.b, col_sum.b);
			s2_last  <= s1_last;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_go) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Output payload: means through the reciprocal multiply.
	always_ff @(posedge clk) begin
		if (s2_go) begin
			red_avg   <= div9(s2_sum.r);
			green_avg <= div9(s2_sum.g);
			blue_avg  <= div9(s2_sum.b);
			frame_end <= s2_last;
		end
	end

`ifndef SYNTHESIS
	// The raster position never leaves the input image.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		SIZE_W'(col_q) <= side_m1)
		else $error("column position beyond the input side");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= side_m1)
		else $error("row position beyond the input side");

	// The last pixel of a frame is always an interior one.
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && s1_last |-> s1_emit)
		else $error("frame end on a border pixel");

	// Input is held back only by a full stage 1.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid)
		else $error("input stalled with stage 1 empty");

	// A taken pixel always lands in stage 1.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_valid)
		else $error("accepted pixel lost before stage 1");
`endif

endmodule

[sv/bb3_ram.sv]
// ---------------------------------------------------------------------------
// bb3_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; the read data is registered and holds
// its value in cycles without a read.
// ---------------------------------------------------------------------------
module bb3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Storage write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[dv/tb_box_blur_3x3_rgb_crop_core.sv]
// ---------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_crop_core: self-checking bench of the 3x3 box blur core
// Streams RGB frames through the core under random idling on both channels,
// predicts every cropped interior mean and compares each output request with it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb_crop_core;
	import bb3_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int NEIGHBOURS    = 9;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_PIXELS = 600;
	localparam int HOLD_CYCLES   = 100;
	localparam int MAX_GAP       = 7;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} mean_t;

	// Clock, reset and the ports of the core; every input that the bench drives is known from time zero.
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [CH_W-1:0]   red_in    = '0;
	logic [CH_W-1:0]   green_in  = '0;
	logic [CH_W-1:0]   blue_in   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CH_W-1:0]   red_avg;
	logic [CH_W-1:0]   green_avg;
	logic [CH_W-1:0]   blue_avg;
	logic              frame_end;

	// Mirror of the core state used for prediction.
	logic [SIZE_W-1:0] size_reg = SIZE_RESET;
	logic [PIX_W-1:0]  upper_line [LINE_DEPTH] = '{default: '0};
	logic [PIX_W-1:0]  middle_line [LINE_DEPTH] = '{default: '0};
	logic [PIX_W-1:0]  window_cols [6] = '{default: '0};
	int                col_pos = 0;
	int                row_pos = 0;

	// Means still owed by the core, oldest first.
	mean_t             expected_means [$];

	// Bench control of the stimulus, the output side and the watchdog.
	bit                sender_idle   = 1'b1;
	bit                receiver_idle = 1'b1;
	int                hold_request  = 0;
	int                hold_left     = 0;
	int                stall_left    = 0;
	int                error_count   = 0;
	int                pixels_sent   = 0;
	int                cycle_count   = 0;

	box_blur_3x3_rgb_crop_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_avg   (red_avg),
		.green_avg (green_avg),
		.blue_avg  (blue_avg),
		.frame_end (frame_end)
	);

	always #HALF_PERIOD clk = ~clk;

	// Input side length of the current frame; sizes out of range are clamped.
	function automatic int frame_side();
		if (size_reg == 0)
			return 3;
		if (size_reg > SIZE_MAX)
			return MAX_INTERIOR + 2;
		return int'(size_reg) + 2;
	endfunction

	function automatic int frame_pixels();
		return frame_side() * frame_side();
	endfunction

	// Channel byte that favors the two extremes now and then.
	function automatic logic [CH_W-1:0] random_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Advance the mirrored window by one pixel and queue the mean it produces.
	function automatic void blur_predict(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] b);
		int               side;
		int               c;
		int               rr;
		int               sum_r;
		int               sum_g;
		int               sum_b;
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] cells [NEIGHBOURS];
		mean_t            m;

		side = frame_side();
		c = col_pos;
		rr = row_pos;
		px = {b, g, r};
		top = upper_line[c];
		mid = middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = px;

		// Only interior positions give a mean; the border is cropped.
		if (rr >= 2 && c >= 2) begin
			for (int k = 0; k < 6; k++)
				cells[k] = window_cols[k];
			cells[6] = top;
			cells[7] = mid;
			cells[8] = px;
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			for (int k = 0; k < NEIGHBOURS; k++) begin
				sum_r += cells[k][CH_W-1:0];
				sum_g += cells[k][2*CH_W-1:CH_W];
				sum_b += cells[k][3*CH_W-1:2*CH_W];
			end
			m.red   = CH_W'(sum_r / NEIGHBOURS);
			m.green = CH_W'(sum_g / NEIGHBOURS);
			m.blue  = CH_W'(sum_b / NEIGHBOURS);
			m.last  = (rr == side - 1) && (c == side - 1);
			expected_means.push_back(m);
		end

		// Shift the window left by one column.
		window_cols[0] = window_cols[3];
		window_cols[1] = window_cols[4];
		window_cols[2] = window_cols[5];
		window_cols[3] = top;
		window_cols[4] = mid;
		window_cols[5] = px;

		// Raster position, wrapping at the end of the frame.
		c++;
		if (c >= side) begin
			c = 0;
			rr++;
			if (rr >= side)
				rr = 0;
		end
		col_pos = c;
		row_pos = rr;
	endfunction

	// Offer one pixel, after a random gap while the sender idles, and hold it until the core takes it.
	task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] b);
		int gap;

		gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		do @(posedge clk); while (in_stall);
		blur_predict(r, g, b);
		pixels_sent++;
	endtask

	task automatic send_pixels(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(random_channel(), random_channel(), random_channel());
	endtask

	// Stop offering, wait for every owed mean, then let the pipeline empty.
	task automatic finish_phase();
		in_valid <= 1'b0;
		while (expected_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Size register write; it also restarts the frame.
	task automatic write_size(input logic [SIZE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		size_reg = value;
		col_pos  = 0;
		row_pos  = 0;
		@(posedge clk);
	endtask

	// The size after reset, seen through the first rows of a frame.
	task automatic test_reset_size();
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		send_pixels(3 * frame_side() + 1);
		finish_phase();
	endtask

	// Zero acts as the smallest size; a full frame of ones, then a full frame of zeros after the wrap.
	// A partial frame at the smallest size follows, which the next size write cuts short.
	task automatic test_small_extremes();
		write_size('0);
		repeat (frame_pixels()) send_pixel('1, '1, '1);
		repeat (frame_pixels()) send_pixel('0, '0, '0);
		finish_phase();
		write_size(SIZE_MIN);
		send_pixel('1, '0, '1);
		send_pixel('0, '1, '0);
		send_pixel('1, '1, '0);
		send_pixel('0, '0, '1);
		finish_phase();
	endtask

	// The largest size, written exactly and from above the limit.
	task automatic test_largest_size();
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		write_size(SIZE_MAX);
		send_pixels(3 * frame_side() + 2);
		finish_phase();
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		write_size('1);
		send_pixels(3 * frame_side() + 2);
		finish_phase();
	endtask

	// Mostly whole frames at small random sizes, some cut short or continued.
	// The first pass always writes a small size so no huge frame is streamed.
	task automatic test_random_frames();
		int start;
		int s;
		int roll;
		int frames;

		start = pixels_sent;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			sender_idle   = ($urandom_range(0, 3) != 0);
			receiver_idle = ($urandom_range(0, 3) != 0);
			roll = $urandom_range(0, 19);
			if (roll < 14)
				s = $urandom_range(1, 5);
			else if (roll < 19)
				s = $urandom_range(6, 12);
			else
				s = $urandom_range(13, 18);
			if (pixels_sent == start || $urandom_range(0, 4) != 0)
				write_size(SIZE_W'(s));
			frames = (frame_side() <= 7) ? $urandom_range(1, 3) : 1;
			if ($urandom_range(0, 5) == 0)
				send_pixels($urandom_range(1, frame_pixels() - 1));
			else
				send_pixels(frames * frame_pixels());
			finish_phase();
		end
	endtask

	// The output holds off for a long stretch while pixels keep coming.
	task automatic test_backpressure();
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		write_size(SIZE_W'(4));
		hold_request = HOLD_CYCLES;
		send_pixels(2 * frame_pixels());
		finish_phase();
	endtask

	// Output side: check each taken request, then draw the next stall.
	always @(posedge clk) begin : result_side
		logic  taken;
		mean_t got;
		mean_t want;

		taken = out_valid && !out_stall;
		got = {red_avg, green_avg, blue_avg, frame_end};
		if (taken) begin
			if (expected_means.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%0t: unexpected result r=%0d g=%0d b=%0d end=%0b", $realtime,
						got.red, got.green, got.blue, got.last);
			end else begin
				want = expected_means.pop_front();
				if (got !== want) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: mismatch expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
							$realtime, want.red, want.green, want.blue, want.last,
							got.red, got.green, got.blue, got.last);
				end
			end
			stall_left = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
		end
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_small_extremes();
		test_largest_size();
		test_random_frames();
		test_backpressure();
		error_count += expected_means.size();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
